/* rtl/stick_to_wheel_speed_mixer_unit_defines.svh */
// assertion macros shared by the checker
`ifndef STICK_TO_WHEEL_SPEED_MIXER_UNIT_DEFINES_SVH
`define STICK_TO_WHEEL_SPEED_MIXER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SWSM_ASSERT_HOLDS(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swsm check failed");

// next-cycle implication
`define SWSM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swsm check failed");

`endif

/* rtl/swsm_pkg.sv */
`default_nettype none
package swsm_pkg;

	typedef enum logic [2:0] {
		REG_STOP       = 3'd0,
		REG_STRAIGHT   = 3'd1,
		REG_SPIN       = 3'd2,
		REG_FWD_RIGHT  = 3'd3,
		REG_FWD_LEFT   = 3'd4,
		REG_BACK_LEFT  = 3'd5,
		REG_BACK_RIGHT = 3'd6
	} region_t;

	localparam logic [2:0] CFG_DB_LOW     = 3'd0;
	localparam logic [2:0] CFG_DB_HIGH    = 3'd1;
	localparam logic [2:0] CFG_STICK_MIN  = 3'd2;
	localparam logic [2:0] CFG_STICK_MAX  = 3'd3;
	localparam logic [2:0] CFG_SPEED_MAX  = 3'd4;
	localparam logic [2:0] CFG_SPEED_ZERO = 3'd5;

	localparam int VMAX_W  = 14;
	localparam int VZ_W    = 15;
	localparam int DC_W    = 17;
	localparam int SPEED_W = 16;
	localparam int SCALE_W = 11;
	localparam int PROD_W  = 26;

	localparam logic [SCALE_W-1:0] SCALE_LOW  = 11'd1000;
	localparam logic [SCALE_W-1:0] SCALE_HIGH = 11'd2000;

	localparam logic signed [SPEED_W-1:0] SPEED_HI = 16'sh7fff;
	localparam logic signed [SPEED_W-1:0] SPEED_LO = 16'sh8000;

	localparam logic [VMAX_W-1:0] RST_SPEED_MAX  = 14'd100;
	localparam logic [VZ_W-1:0]   RST_SPEED_ZERO = 15'd0;

endpackage
`default_nettype wire

/* rtl/swsm_div.sv */
`default_nettype none
// restoring divider, one quotient bit per stage, unsigned magnitudes
module swsm_div #(
	parameter int NW = 29,
	parameter int DW = 13,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] side_out
);

	logic          v_q  [NW];
	logic [NW-1:0] n_q  [NW];
	logic [NW-1:0] qt_q [NW];
	logic [DW-1:0] r_q  [NW];
	logic [DW-1:0] d_q  [NW];
	logic [SW-1:0] s_q  [NW];

	genvar k;
	generate
		for (k = 0; k < NW; k++) begin : g_st
			logic          vi;
			logic [NW-1:0] ni;
			logic [NW-1:0] qi;
			logic [DW-1:0] ri;
			logic [DW-1:0] di;
			logic [SW-1:0] si;
			logic [DW:0]   t;
			logic [DW:0]   diff;
			logic          ge;

			if (k == 0) begin : g_first
				assign vi = in_valid;
				assign ni = num;
				assign qi = '0;
				assign ri = '0;
				assign di = den;
				assign si = side_in;
			end else begin : g_next
				assign vi = v_q[k-1];
				assign ni = n_q[k-1];
				assign qi = qt_q[k-1];
				assign ri = r_q[k-1];
				assign di = d_q[k-1];
				assign si = s_q[k-1];
			end

			assign t    = {ri, ni[NW-1]};
			assign diff = t - {1'b0, di};
			// no borrow means the partial remainder covers the divisor
			assign ge   = !diff[DW];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_q[k] <= 1'b0;
				end else if (en) begin
					v_q[k] <= vi;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					n_q[k]  <= {ni[NW-2:0], 1'b0};
					r_q[k]  <= ge ? diff[DW-1:0] : t[DW-1:0];
					qt_q[k] <= {qi[NW-2:0], ge};
					d_q[k]  <= di;
					s_q[k]  <= si;
				end
			end
		end
	endgenerate

	assign out_valid = v_q[NW-1];
	assign quo       = qt_q[NW-1];
	assign side_out  = s_q[NW-1];

endmodule
`default_nettype wire

/* rtl/swsm_fifo.sv */
`default_nettype none
module swsm_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

/* rtl/swsm_front.sv */
`default_nettype none
// clamps the sticks, picks the drive region and forms both map numerators
module swsm_front #(
	parameter int STICK_BITS = 12,
	localparam int XW = STICK_BITS + 2,
	localparam int MW = STICK_BITS + 1,
	localparam int NW = STICK_BITS + 17,
	localparam int QW = 3 + swsm_pkg::VZ_W + 2 + 2 * (NW + MW) + 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [STICK_BITS-1:0]       throttle_stick,
	input  logic [STICK_BITS-1:0]       steer_stick,
	input  logic [STICK_BITS-1:0]       db_low,
	input  logic [STICK_BITS-1:0]       db_high,
	input  logic [STICK_BITS-1:0]       stick_min,
	input  logic [STICK_BITS-1:0]       stick_max,
	input  logic [swsm_pkg::VMAX_W-1:0] speed_max,
	input  logic [swsm_pkg::VZ_W-1:0]   speed_zero,
	output logic                        push,
	output logic [QW-1:0]               push_data,
	input  logic                        full
);

	localparam int DCW = swsm_pkg::DC_W;

	logic adv;

	// stage 1
	logic [STICK_BITS-1:0] t0, tc, s0, sc;
	logic                  t_in, s_in;
	swsm_pkg::region_t     rg;
	logic signed [XW-1:0]  tx, sx, lo_m, hi_p, smin_x, smax_x;
	logic signed [XW-1:0]  x, a, b, sa, sb;
	logic signed [DCW-1:0] vmax_e, vz_e, c_e, d_e;

	logic                  v_s1;
	swsm_pkg::region_t     rg_s1;
	logic signed [XW-1:0]  dx_s1, sp_s1, sdx_s1, ssp_s1;
	logic signed [DCW-1:0] dc_s1;
	logic [swsm_pkg::VZ_W-1:0] c_s1;

	// stage 2
	logic [MW-1:0]         dxm, spm, sdxm, sspm;
	logic [15:0]           dcm;
	logic [NW-1:0]         num, snum;
	logic                  v_s2;
	logic [QW-1:0]         data_s2;

	assign adv      = !v_s2 || !full;
	assign in_stall = !adv;
	assign push     = v_s2 && !full;
	assign push_data = data_s2;

	always_comb begin
		t0 = (throttle_stick < stick_min) ? stick_min : throttle_stick;
		tc = (t0 > stick_max) ? stick_max : t0;
		s0 = (steer_stick < stick_min) ? stick_min : steer_stick;
		sc = (s0 > stick_max) ? stick_max : s0;
		t_in = (tc >= db_low) && (tc <= db_high);
		s_in = (sc >= db_low) && (sc <= db_high);

		priority if (t_in && s_in)               rg = swsm_pkg::REG_STOP;
		else if (s_in)                           rg = swsm_pkg::REG_STRAIGHT;
		else if (t_in)                           rg = swsm_pkg::REG_SPIN;
		else if (tc > db_high && sc > db_high)   rg = swsm_pkg::REG_FWD_RIGHT;
		else if (tc > db_high && sc < db_low)    rg = swsm_pkg::REG_FWD_LEFT;
		else if (tc < db_low && sc < db_low)     rg = swsm_pkg::REG_BACK_LEFT;
		else                                     rg = swsm_pkg::REG_BACK_RIGHT;

		tx     = signed'({2'b00, tc});
		sx     = signed'({2'b00, sc});
		smin_x = signed'({2'b00, stick_min});
		smax_x = signed'({2'b00, stick_max});
		hi_p   = signed'({2'b00, db_high}) + XW'(1);
		lo_m   = signed'({2'b00, db_low}) - XW'(1);
		vmax_e = signed'({3'b000, speed_max});
		vz_e   = DCW'(signed'(speed_zero));

		x  = tx;
		a  = '0;
		b  = '0;
		sa = '0;
		sb = '0;
		c_e = vz_e;
		d_e = vz_e;
		unique case (rg)
			swsm_pkg::REG_STOP: begin
				// zero span makes the map give speed_zero
			end
			swsm_pkg::REG_STRAIGHT: begin
				a = smin_x; b = smax_x; c_e = -vmax_e; d_e = vmax_e;
			end
			swsm_pkg::REG_SPIN: begin
				x = sx; a = smin_x; b = smax_x; c_e = -vmax_e; d_e = vmax_e;
			end
			swsm_pkg::REG_FWD_RIGHT: begin
				a = hi_p; b = smax_x; d_e = vmax_e; sa = hi_p; sb = smax_x;
			end
			swsm_pkg::REG_FWD_LEFT: begin
				a = hi_p; b = smax_x; d_e = vmax_e; sa = lo_m; sb = smin_x;
			end
			swsm_pkg::REG_BACK_LEFT: begin
				a = lo_m; b = smin_x; d_e = -vmax_e; sa = lo_m; sb = smin_x;
			end
			swsm_pkg::REG_BACK_RIGHT: begin
				a = lo_m; b = smin_x; d_e = -vmax_e; sa = hi_p; sb = smax_x;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rg_s1  <= rg;
			dx_s1  <= x - a;
			sp_s1  <= b - a;
			sdx_s1 <= sx - sa;
			ssp_s1 <= sb - sa;
			dc_s1  <= d_e - c_e;
			c_s1   <= c_e[swsm_pkg::VZ_W-1:0];
		end
	end

	always_comb begin
		dxm  = dx_s1[XW-1]  ? MW'(-dx_s1)  : MW'(dx_s1);
		spm  = sp_s1[XW-1]  ? MW'(-sp_s1)  : MW'(sp_s1);
		sdxm = sdx_s1[XW-1] ? MW'(-sdx_s1) : MW'(sdx_s1);
		sspm = ssp_s1[XW-1] ? MW'(-ssp_s1) : MW'(ssp_s1);
		dcm  = dc_s1[DCW-1] ? 16'(-dc_s1) : 16'(dc_s1);
		num  = {{(NW-MW){1'b0}}, dxm} * {{(NW-16){1'b0}}, dcm};
		snum = {{(NW-MW){1'b0}}, sdxm}
			* {{(NW-swsm_pkg::SCALE_W){1'b0}}, swsm_pkg::SCALE_LOW};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= {rg_s1, c_s1,
				dx_s1[XW-1] ^ dc_s1[DCW-1] ^ sp_s1[XW-1], (sp_s1 == '0),
				num, spm,
				sdx_s1[XW-1] ^ ssp_s1[XW-1], (ssp_s1 == '0),
				snum, sspm};
		end
	end

endmodule
`default_nettype wire

/* rtl/swsm_back.sv */
`default_nettype none
// divides, offsets, saturates and scales the inner wheel
module swsm_back #(
	parameter int STICK_BITS = 12,
	localparam int MW = STICK_BITS + 1,
	localparam int NW = STICK_BITS + 17,
	localparam int QW = 3 + swsm_pkg::VZ_W + 2 + 2 * (NW + MW) + 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  logic [QW-1:0]                q_data,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [swsm_pkg::SPEED_W-1:0] right_speed,
	output logic [swsm_pkg::SPEED_W-1:0] left_speed,
	output logic [2:0]                   drive_region
);

	localparam int VZW = swsm_pkg::VZ_W;
	localparam int SPW = swsm_pkg::SPEED_W;
	localparam int SCW = swsm_pkg::SCALE_W;
	localparam int PW  = swsm_pkg::PROD_W;
	localparam int RW  = NW + 2;
	localparam int S1W = 3 + VZW + 2;
	localparam int S3W = 3 + 2 * SPW + 1;

	function automatic logic signed [SPW-1:0] sat16(input logic signed [RW-1:0] v);
		logic signed [SPW-1:0] r;
		if (v > RW'(swsm_pkg::SPEED_HI)) begin
			r = swsm_pkg::SPEED_HI;
		end else if (v < RW'(swsm_pkg::SPEED_LO)) begin
			r = swsm_pkg::SPEED_LO;
		end else begin
			r = v[SPW-1:0];
		end
		return r;
	endfunction

	logic en;

	// queue fields
	logic [2:0]     q_rg;
	logic [VZW-1:0] q_c;
	logic           q_neg, q_zs, q_sneg, q_szs;
	logic [NW-1:0]  q_num, q_snum;
	logic [MW-1:0]  q_den, q_sden;

	// after first dividers
	logic           v_d1;
	logic [NW-1:0]  quo1, quo2;
	logic [S1W-1:0] side1;
	logic [1:0]     side2;

	// stage b
	swsm_pkg::region_t      rg_d;
	logic signed [VZW-1:0]  c_d;
	logic signed [RW-1:0]   mag_e, sv, raw;
	logic signed [NW:0]     smag, sval;
	logic [SCW-1:0]         scale;
	logic                   v_b;
	swsm_pkg::region_t      rg_b;
	logic signed [SPW-1:0]  r_b, l_b;
	logic [SCW-1:0]         sc_b;

	// stage c
	logic [SPW-1:0]         fm;
	logic                   v_c;
	logic [PW-1:0]          num_c;
	logic [S3W-1:0]         side_c;
	logic [SCW-1:0]         sc_c;

	// after last divider
	logic                   v_d3;
	logic [PW-1:0]          quo3;
	logic [S3W-1:0]         side3;
	swsm_pkg::region_t      rg_e;
	logic [SPW-1:0]         r_e, l_e, other;
	logic                   neg_e;
	logic [SPW:0]           o17;

	logic                   out_v_q;
	logic [SPW-1:0]         right_q, left_q;
	swsm_pkg::region_t      rg_q;

	assign en  = !out_v_q || !out_stall;
	assign pop = en && !q_empty;

	assign {q_rg, q_c, q_neg, q_zs, q_num, q_den, q_sneg, q_szs, q_snum, q_sden} = q_data;

	swsm_div #(.NW(NW), .DW(MW), .SW(S1W)) u_div_speed (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (!q_empty),
		.num      (q_num),
		.den      (q_den),
		.side_in  ({q_rg, q_c, q_neg, q_zs}),
		.out_valid(v_d1),
		.quo      (quo1),
		.side_out (side1)
	);

	swsm_div #(.NW(NW), .DW(MW), .SW(2)) u_div_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (!q_empty),
		.num      (q_snum),
		.den      (q_sden),
		.side_in  ({q_sneg, q_szs}),
		.out_valid(),
		.quo      (quo2),
		.side_out (side2)
	);

	always_comb begin
		rg_d  = swsm_pkg::region_t'(side1[S1W-1 -: 3]);
		c_d   = signed'(side1[VZW+1:2]);
		mag_e = signed'({2'b00, quo1});
		sv    = side1[1] ? -mag_e : mag_e;
		// zero span map gives its low output
		raw   = side1[0] ? RW'(c_d) : sv + RW'(c_d);

		smag = signed'({1'b0, quo2});
		// scale map starts at its low output
		sval = (side2[1] ? -smag : smag) + signed'((NW+1)'(swsm_pkg::SCALE_LOW));
		if (side2[0]) begin
			scale = swsm_pkg::SCALE_LOW;
		end else if (sval < signed'((NW+1)'(swsm_pkg::SCALE_LOW))) begin
			scale = swsm_pkg::SCALE_LOW;
		end else if (sval > signed'((NW+1)'(swsm_pkg::SCALE_HIGH))) begin
			scale = swsm_pkg::SCALE_HIGH;
		end else begin
			scale = sval[SCW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b     <= 1'b0;
			v_c     <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_b     <= v_d1;
			v_c     <= v_b;
			out_v_q <= v_d3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rg_b <= rg_d;
			l_b  <= sat16(raw);
			r_b  <= (rg_d == swsm_pkg::REG_SPIN) ? sat16(-raw) : sat16(raw);
			sc_b <= scale;
		end
	end

	// followed wheel is l_b in every quadrant
	assign fm = l_b[SPW-1] ? SPW'(-l_b) : SPW'(l_b);

	always_ff @(posedge clk) begin
		if (en) begin
			num_c  <= {{(PW-SPW){1'b0}}, fm} * PW'(swsm_pkg::SCALE_LOW);
			side_c <= {rg_b, r_b, l_b, l_b[SPW-1]};
			sc_c   <= sc_b;
		end
	end

	swsm_div #(.NW(PW), .DW(SCW), .SW(S3W)) u_div_inner (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_c),
		.num      (num_c),
		.den      (sc_c),
		.side_in  (side_c),
		.out_valid(v_d3),
		.quo      (quo3),
		.side_out (side3)
	);

	always_comb begin
		rg_e  = swsm_pkg::region_t'(side3[S3W-1 -: 3]);
		r_e   = side3[2*SPW:SPW+1];
		l_e   = side3[SPW:1];
		neg_e = side3[0];
		o17   = neg_e ? -{1'b0, quo3[SPW-1:0]} : {1'b0, quo3[SPW-1:0]};
		other = o17[SPW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rg_q <= rg_e;
			unique case (rg_e)
				swsm_pkg::REG_FWD_RIGHT, swsm_pkg::REG_BACK_RIGHT: begin
					right_q <= other;
					left_q  <= l_e;
				end
				swsm_pkg::REG_FWD_LEFT, swsm_pkg::REG_BACK_LEFT: begin
					right_q <= r_e;
					left_q  <= other;
				end
				default: begin
					right_q <= r_e;
					left_q  <= l_e;
				end
			endcase
		end
	end

	assign out_valid    = out_v_q;
	assign right_speed  = right_q;
	assign left_speed   = left_q;
	assign drive_region = rg_q;

endmodule
`default_nettype wire

/* rtl/stick_to_wheel_speed_mixer_unit.sv */
// Stick to wheel speed mixer for a two-wheel differential drive.
// Input channel: in_valid / in_stall with throttle_stick and steer_stick.
// Output channel: out_valid / out_stall with right_speed, left_speed and
// drive_region. A beat moves on an edge with valid high and stall low.
// Configuration: cfg_we writes cfg_data into register cfg_index on the
// edge; write only while the block holds no beat in flight.
// Throughput: one beat per cycle, sustained while out_stall stays low.
// From input beat to output beat a beat passes the two front stages, the
// queue, the speed and scale dividers (one quotient bit per stage) and
// the 26-stage divider for the inner wheel.
// Reset clears all valid bits and loads the default register values.
// A stalled output holds the whole back pipeline; the two-entry queue
// then fills and in_stall rises once front stage 2 holds a beat.
`default_nettype none
module stick_to_wheel_speed_mixer_unit #(
	parameter int STICK_BITS = 12,
	localparam int CFG_W = (STICK_BITS > 15) ? STICK_BITS : 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [STICK_BITS-1:0] throttle_stick,
	input  logic [STICK_BITS-1:0] steer_stick,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [15:0]    right_speed,
	output logic signed [15:0]    left_speed,
	output logic [2:0]            drive_region,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int MW = STICK_BITS + 1;
	localparam int NW = STICK_BITS + 17;
	localparam int QW = 3 + swsm_pkg::VZ_W + 2 + 2 * (NW + MW) + 2;

	logic [STICK_BITS-1:0]       db_low_q, db_high_q, stick_min_q, stick_max_q;
	logic [swsm_pkg::VMAX_W-1:0] speed_max_q;
	logic [swsm_pkg::VZ_W-1:0]   speed_zero_q;

	logic          push, pop, full, empty;
	logic [QW-1:0] push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_low_q     <= STICK_BITS'(1450);
			db_high_q    <= STICK_BITS'(1550);
			stick_min_q  <= STICK_BITS'(1000);
			stick_max_q  <= STICK_BITS'(2000);
			speed_max_q  <= swsm_pkg::RST_SPEED_MAX;
			speed_zero_q <= swsm_pkg::RST_SPEED_ZERO;
		end else if (cfg_we) begin
			unique case (cfg_index)
				swsm_pkg::CFG_DB_LOW:     db_low_q     <= cfg_data[STICK_BITS-1:0];
				swsm_pkg::CFG_DB_HIGH:    db_high_q    <= cfg_data[STICK_BITS-1:0];
				swsm_pkg::CFG_STICK_MIN:  stick_min_q  <= cfg_data[STICK_BITS-1:0];
				swsm_pkg::CFG_STICK_MAX:  stick_max_q  <= cfg_data[STICK_BITS-1:0];
				swsm_pkg::CFG_SPEED_MAX:  speed_max_q  <= cfg_data[swsm_pkg::VMAX_W-1:0];
				swsm_pkg::CFG_SPEED_ZERO: speed_zero_q <= cfg_data[swsm_pkg::VZ_W-1:0];
				default: begin
				end
			endcase
		end
	end

	swsm_front #(.STICK_BITS(STICK_BITS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.throttle_stick(throttle_stick),
		.steer_stick   (steer_stick),
		.db_low        (db_low_q),
		.db_high       (db_high_q),
		.stick_min     (stick_min_q),
		.stick_max     (stick_max_q),
		.speed_max     (speed_max_q),
		.speed_zero    (speed_zero_q),
		.push          (push),
		.push_data     (push_data),
		.full          (full)
	);

	swsm_fifo #(.W(QW), .DEPTH(2)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty)
	);

	swsm_back #(.STICK_BITS(STICK_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (empty),
		.q_data      (pop_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.right_speed (right_speed),
		.left_speed  (left_speed),
		.drive_region(drive_region)
	);

endmodule
`default_nettype wire

/* rtl/swsm_chk.sv */
`default_nettype none
`include "stick_to_wheel_speed_mixer_unit_defines.svh"
module swsm_chk #(
	parameter int STICK_BITS = 12,
	localparam int CFG_W = (STICK_BITS > 15) ? STICK_BITS : 15
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [STICK_BITS-1:0] throttle_stick,
	input logic [STICK_BITS-1:0] steer_stick,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic signed [15:0]    right_speed,
	input logic signed [15:0]    left_speed,
	input logic [2:0]            drive_region,
	input logic                  cfg_we,
	input logic [2:0]            cfg_index,
	input logic [CFG_W-1:0]      cfg_data
);

	`SWSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`SWSM_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(right_speed) && $stable(left_speed) && $stable(drive_region))
	`SWSM_ASSERT_HOLDS(a_even_drive, out_valid && (drive_region == swsm_pkg::REG_STOP || drive_region == swsm_pkg::REG_STRAIGHT), right_speed == left_speed)
	`SWSM_ASSERT_HOLDS(a_spin_mirror, out_valid && drive_region == swsm_pkg::REG_SPIN && left_speed > -16'sd32767 && left_speed < 16'sd32767, right_speed == -left_speed)

endmodule

bind stick_to_wheel_speed_mixer_unit swsm_chk #(.STICK_BITS(STICK_BITS)) u_chk (.*);
`default_nettype wire
